@@ rtl/ast_pkg.sv @@
`default_nettype none

package ast_pkg;

    // Field widths of the stream payloads (fixed by the item layout).
    localparam int ACTION_W   = 2;
    localparam int IN_VALUE_W = 32;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int READ_W     = 32;

    // Slave tdata: action, value, index, padded to whole bytes.
    localparam int S_FIELDS_W = ACTION_W + IN_VALUE_W + INDEX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Master tdata: found, count, read_value, rejected, padded to whole bytes.
    localparam int M_FIELDS_W = 1 + COUNT_W + READ_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_ADD    = 2'd0;
    localparam t_action ACT_REMOVE = 2'd1;
    localparam t_action ACT_QUERY  = 2'd2;
    localparam t_action ACT_READ   = 2'd3;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic active;   // cell holds a live entry (position below the count)
        logic load;     // write the incoming value into this cell
        logic shift;    // remove commit: take neighbor's entry if at/after match
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/ast_cell.sv @@
`default_nettype none

module ast_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                     i_clk,
    input  ast_pkg::t_cell_ctl      i_ctl,
    input  wire  [VALUE_WIDTH-1:0]  i_value,
    input  wire  [VALUE_WIDTH-1:0]  i_next_entry,
    input  wire                     i_seen,
    output logic [VALUE_WIDTH-1:0]  o_entry,
    output logic                    o_seen
);
    import ast_pkg::*;

    logic [VALUE_WIDTH-1:0] r_entry;
    logic [VALUE_WIDTH-1:0] n_entry;
    logic                   w_match;

    // Match only against live entries; pass "seen" on to the next cell.
    assign w_match = i_ctl.active && (r_entry == i_value);
    assign o_seen  = i_seen || w_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_value;
        end else if (i_ctl.shift && o_seen) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ rtl/array_set_table.sv @@
`default_nettype none

// Channel   Dir  tdata fields (lsb first)                         Bits
// s (in)    in   action[1:0] value[33:2] index[37:34] pad          40
// m (out)   out  found[0] count[5:1] read_value[37:6] rejected[38] 40
//
// Each item is accepted and captured; then, in the execute state, the row of
// cells compares, shifts or loads, or the indexed cell is read, and the
// result is registered. The match ripples through the cell row as a "seen"
// chain, which sets the path length of the execute step.
// Reset (synchronous, active low) empties the store; entry contents stay
// undefined until written. A stalled result holds in the output register;
// the next item is still accepted and waits in its execute cycle.

module array_set_table #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    input  wire  [ast_pkg::S_TDATA_W-1:0] i_s_tdata,   // action, value, index
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    output logic [ast_pkg::M_TDATA_W-1:0] o_m_tdata    // found, count, read_value, rejected
);
    import ast_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);      // count width
    localparam int RD_NUM = (CAPACITY < 16) ? CAPACITY : 16; // cells reachable by index

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Sequencer state and captured item
    logic                   r_state, n_state;
    t_action                r_action;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [INDEX_W-1:0]     r_index;
    logic [CW-1:0]          r_count, n_count;

    // Output register
    logic                   r_out_valid, n_out_valid;
    logic                   r_found;
    logic [COUNT_W-1:0]     r_out_count;
    logic [READ_W-1:0]      r_read;
    logic                   r_rejected;

    logic                   w_accept;
    logic                   w_commit;
    logic                   w_hit;
    logic                   w_full;
    logic                   w_add_new;
    logic                   w_del;
    logic                   w_rd_ok;
    logic [VALUE_WIDTH-1:0] w_rd_entry;
    logic [READ_W-1:0]      w_rd_out;
    logic                   w_found;
    logic [COUNT_W-1:0]     w_count_out;

    // Input field unpacking, value masked to the stored width
    logic [VALUE_WIDTH+IN_VALUE_W-1:0] w_in_ext;
    logic [VALUE_WIDTH+READ_W-1:0]     w_rd_ext;
    logic [CW+COUNT_W-1:0]             w_cnt_ext;
    logic [CW+INDEX_W-1:0]             w_idx_x;
    logic [CW+INDEX_W-1:0]             w_cnt_x;

    // Cell row
    logic [VALUE_WIDTH-1:0] w_entry [CAPACITY];
    logic [CAPACITY:0]      w_seen;
    t_cell_ctl              w_ctl   [CAPACITY];

    assign w_in_ext = {{VALUE_WIDTH{1'b0}}, i_s_tdata[ACTION_W +: IN_VALUE_W]};

    // Accept only when idle; the result register is parted from the input.
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    // Execute finishes once the result register can take the new beat.
    assign w_commit   = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    assign w_seen[0] = 1'b0;
    assign w_hit     = w_seen[CAPACITY];
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_add_new = (r_action == ACT_ADD) && !w_hit && !w_full;
    assign w_del     = (r_action == ACT_REMOVE) && w_hit;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_ctl[gi].active = (r_count > CW'(gi));
            assign w_ctl[gi].load   = w_commit && w_add_new && (r_count == CW'(gi));
            assign w_ctl[gi].shift  = w_commit && w_del;

            ast_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl[gi]),
                .i_value      (r_value),
                // Last cell has no upper neighbor; its value past the count is dead.
                .i_next_entry (w_entry[(gi + 1 < CAPACITY) ? gi + 1 : gi]),
                .i_seen       (w_seen[gi]),
                .o_entry      (w_entry[gi]),
                .o_seen       (w_seen[gi+1])
            );
        end
    endgenerate

    // Read port: index compared against count, then a small mux over the
    // cells the index field can reach.
    assign w_idx_x = {{CW{1'b0}}, r_index};
    assign w_cnt_x = {{INDEX_W{1'b0}}, r_count};
    assign w_rd_ok = (r_action == ACT_READ) && (w_idx_x < w_cnt_x);

    always_comb begin
        w_rd_entry = '0;
        for (int i = 0; i < RD_NUM; i++) begin
            if (r_index == INDEX_W'(i)) begin
                w_rd_entry = w_entry[i];
            end
        end
    end

    assign w_rd_ext = {{READ_W{1'b0}}, w_rd_entry};
    assign w_rd_out = w_rd_ok ? w_rd_ext[READ_W-1:0] : '0;
    assign w_found  = (r_action == ACT_READ) ? w_rd_ok : w_hit;

    // Next count and its 5-bit view for the result
    always_comb begin
        n_count = r_count;
        if (w_commit && w_add_new) begin
            n_count = r_count + CW'(1);
        end else if (w_commit && w_del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_cnt_ext   = {{COUNT_W{1'b0}}, n_count};
    assign w_count_out = w_cnt_ext[COUNT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the item on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_s_tdata[ACTION_W-1:0];
            r_value  <= w_in_ext[VALUE_WIDTH-1:0];
            r_index  <= i_s_tdata[ACTION_W+IN_VALUE_W +: INDEX_W];
        end
    end

    // Load the result beat; hold it while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_found     <= w_found;
            r_out_count <= w_count_out;
            r_read      <= w_rd_out;
            r_rejected  <= (r_action == ACT_ADD) && !w_hit && w_full;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                         r_rejected, r_read, r_out_count, r_found};

endmodule

`default_nettype wire

@@ rtl/ast_chk.sv @@
`default_nettype none

module ast_chk #(
    parameter int CAPACITY = 16
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire [39:0] i_s_tdata,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [39:0] o_m_tdata
);

    // Stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed under stall");

    // One item at a time: ready drops right after an accepted beat.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second beat accepted while item in flight");

    // A fresh result follows an accepted beat, by way of the execute state and the output register.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result without matching input beat");

    // A rejected add reports a full store, not found, no read data.
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[38] |->
            !o_m_tdata[0] && (o_m_tdata[37:6] == 32'd0) &&
            (o_m_tdata[5:1] == 5'(CAPACITY)))
        else $error("bad rejected result");

endmodule

bind array_set_table ast_chk #(
    .CAPACITY (CAPACITY)
) u_ast_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
